### rtl/bppm_pkg.sv
// Shared types, widths and constants of the buffer pool pin manager.
package bppm_pkg;

   localparam int POOL_FRAMES_DEF = 8;
   localparam int PIN_BITS_DEF    = 8;
   localparam int MAX_RESULTS     = 8;
   localparam int K_BITS          = $clog2(MAX_RESULTS);

   localparam int OP_BITS     = 2;
   localparam int FILE_BITS   = 16;
   localparam int BLOCK_BITS  = 32;
   localparam int INDEX_BITS  = 3;
   localparam int TXN_BITS    = 16;
   localparam int LSN_BITS    = 32;
   localparam int STATUS_BITS = 2;
   localparam int AVAIL_BITS  = 4;
   localparam int FIU_BITS    = 4;

   localparam int MAX_ACTIVE = (1 << FIU_BITS) - 1;
   localparam logic [FIU_BITS-1:0] FIU_RESET = FIU_BITS'(8);
   localparam logic signed [LSN_BITS-1:0] NO_LSN = '1;

   typedef enum logic [OP_BITS-1:0] {
      OP_PIN    = 2'd0,
      OP_UNPIN  = 2'd1,
      OP_MODIFY = 2'd2,
      OP_FLUSH  = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK        = 2'd0,
      STAT_NO_FRAME  = 2'd1,
      STAT_UNPIN_ERR = 2'd2,
      STAT_PIN_SAT   = 2'd3
   } rsp_status_type;

   typedef struct packed {
      logic lookup;
      logic commit;
      logic count_start;
      logic count_step;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic more;
      logic count_done;
   } dp_sts_type;

endpackage

### rtl/bppm_ctrl.sv
// Sequencing state machine of the buffer pool pin manager.
module bppm_ctrl
   import bppm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        csr_write_enable,
   input  dp_sts_type  sts,
   output ctl_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EXEC  = 3'b010,
      ST_COUNT = 3'b100
   } ctl_state_type;

   ctl_state_type state_ff, state_in;

   always_comb begin
      req_ready       = (state_ff == ST_IDLE) && !csr_write_enable;
      cmd.lookup      = req_valid && req_ready;
      cmd.count_start = (state_ff == ST_IDLE) && csr_write_enable;
      cmd.commit      = (state_ff == ST_EXEC) && sts.out_free;
      cmd.count_step  = (state_ff == ST_COUNT);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.count_start) begin
               state_in = ST_COUNT;
            end else if (cmd.lookup) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd.commit && !sts.more) begin
               state_in = ST_IDLE;
            end
         end
         ST_COUNT: begin
            if (sts.count_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_EXEC)
      else $error("accepted request did not enter execution");

   a_commit_done: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !sts.more |=> state_ff == ST_IDLE)
      else $error("final result did not return to idle");

   a_csr_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && csr_write_enable |=> state_ff == ST_COUNT)
      else $error("register write did not start recount");

endmodule

### rtl/bppm_datapath.sv
// Frame table, lookup lanes and result register of the buffer pool pin manager.
module bppm_datapath
   import bppm_pkg::*;
#(
   parameter int POOL_FRAMES = POOL_FRAMES_DEF,
   parameter int PIN_BITS    = PIN_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ctl_cmd_type                   cmd,
   output dp_sts_type                    sts,
   input  logic [FIU_BITS-1:0]           csr_write_data,
   input  logic [OP_BITS-1:0]            req_operation,
   input  logic [FILE_BITS-1:0]          req_file_id,
   input  logic [BLOCK_BITS-1:0]         req_block_number,
   input  logic [INDEX_BITS-1:0]         req_frame_index,
   input  logic [TXN_BITS-1:0]           req_txn_id,
   input  logic signed [LSN_BITS-1:0]    req_log_seq,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [STATUS_BITS-1:0]        rsp_status,
   output logic [INDEX_BITS-1:0]         rsp_granted_frame,
   output logic                          rsp_hit,
   output logic                          rsp_fetch,
   output logic                          rsp_writeback,
   output logic [FILE_BITS-1:0]          rsp_wb_file_id,
   output logic [BLOCK_BITS-1:0]         rsp_wb_block_number,
   output logic signed [LSN_BITS-1:0]    rsp_wb_log_seq,
   output logic [AVAIL_BITS-1:0]         rsp_available,
   output logic                          rsp_last
);

   localparam int SCAN_FRAMES = (POOL_FRAMES < MAX_ACTIVE) ? POOL_FRAMES : MAX_ACTIVE;
   localparam int TGT_BITS    = $clog2(SCAN_FRAMES);
   localparam logic [PIN_BITS-1:0] PIN_MAX = '1;
   localparam logic [K_BITS-1:0]   K_LAST  = K_BITS'(MAX_RESULTS - 1);

   function automatic logic [FIU_BITS-1:0] clamp_active(input logic [FIU_BITS-1:0] v);
      logic [FIU_BITS-1:0] r;
      if (v == '0) begin
         r = FIU_BITS'(1);
      end else if (32'(v) > SCAN_FRAMES) begin
         r = FIU_BITS'(SCAN_FRAMES);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [TGT_BITS-1:0] first_set(input logic [SCAN_FRAMES-1:0] v);
      logic [TGT_BITS-1:0] r;
      r = '0;
      for (int i = SCAN_FRAMES - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = TGT_BITS'(i);
         end
      end
      return r;
   endfunction

   // frame table
   logic [SCAN_FRAMES-1:0]       valid_ff, valid_in;
   logic [SCAN_FRAMES-1:0]       dirty_ff, dirty_in;
   logic [FILE_BITS-1:0]         file_ff  [SCAN_FRAMES];
   logic [BLOCK_BITS-1:0]        block_ff [SCAN_FRAMES];
   logic [PIN_BITS-1:0]          pin_ff   [SCAN_FRAMES];
   logic [TXN_BITS-1:0]          txn_ff   [SCAN_FRAMES];
   logic signed [LSN_BITS-1:0]   lsn_ff   [SCAN_FRAMES];
   logic [AVAIL_BITS-1:0]        avail_ff, avail_in;
   logic [FIU_BITS-1:0]          act_n_ff, act_n_in;
   logic [TGT_BITS-1:0]          scan_ff, scan_in;

   // latched request and lookup outcome
   op_type                       op_ff;
   logic [FILE_BITS-1:0]         rq_file_ff;
   logic [BLOCK_BITS-1:0]        rq_block_ff;
   logic [TXN_BITS-1:0]          rq_txn_ff;
   logic signed [LSN_BITS-1:0]   rq_lsn_ff;
   logic                         fi_ok_ff;
   logic                         hit_ff;
   logic                         free_ff;
   logic [TGT_BITS-1:0]          tgt_ff, tgt_in;
   logic [SCAN_FRAMES-1:0]       rem_ff;
   logic [K_BITS-1:0]            k_ff;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_status_type               rsp_status_ff;
   logic [INDEX_BITS-1:0]        rsp_frame_ff;
   logic                         rsp_hit_ff, rsp_fetch_ff, rsp_wb_ff, rsp_last_ff;
   logic [FILE_BITS-1:0]         rsp_wbf_ff;
   logic [BLOCK_BITS-1:0]        rsp_wbb_ff;
   logic signed [LSN_BITS-1:0]   rsp_wbl_ff;
   logic [AVAIL_BITS-1:0]        rsp_avail_ff;

   // lookup lanes
   logic [SCAN_FRAMES-1:0] active, pin_zero, hit_vec, free_vec, flush_vec;
   op_type                 req_op;
   logic                   req_fi_ok;
   logic [TGT_BITS-1:0]    look_tgt;

   always_comb begin
      req_op    = op_type'(req_operation);
      req_fi_ok = FIU_BITS'(req_frame_index) < act_n_ff;
      for (int i = 0; i < SCAN_FRAMES; i++) begin
         active[i]    = FIU_BITS'(i) < act_n_ff;
         pin_zero[i]  = pin_ff[i] == '0;
         hit_vec[i]   = active[i] && valid_ff[i] && (file_ff[i] == req_file_id)
                        && (block_ff[i] == req_block_number);
         free_vec[i]  = active[i] && pin_zero[i];
         flush_vec[i] = active[i] && valid_ff[i] && dirty_ff[i]
                        && (txn_ff[i] == req_txn_id);
      end
      case (req_op)
         OP_PIN: begin
            look_tgt = (hit_vec != '0) ? first_set(hit_vec) : first_set(free_vec);
         end
         OP_UNPIN, OP_MODIFY: begin
            look_tgt = TGT_BITS'(req_frame_index);
         end
         OP_FLUSH: begin
            look_tgt = first_set(flush_vec);
         end
         default: begin
            look_tgt = '0;
         end
      endcase
   end

   // execution of the latched request
   logic [PIN_BITS-1:0]        sel_pin;
   logic [FILE_BITS-1:0]       sel_file;
   logic [BLOCK_BITS-1:0]      sel_block;
   logic signed [LSN_BITS-1:0] sel_lsn;
   logic                       sel_valid, sel_dirty;
   logic [SCAN_FRAMES-1:0]     rem_next;

   rsp_status_type             r_status;
   logic [INDEX_BITS-1:0]      r_frame;
   logic                       r_hit, r_fetch, r_wb, r_last, r_more;
   logic [FILE_BITS-1:0]       r_wbf;
   logic [BLOCK_BITS-1:0]      r_wbb;
   logic signed [LSN_BITS-1:0] r_wbl;

   logic                       pin_we, tag_we, dirty_clr, dirty_set, txn_we, lsn_we;
   logic                       avail_inc, avail_dec;
   logic [PIN_BITS-1:0]        pin_wdata;
   logic [AVAIL_BITS-1:0]      avail_next;

   always_comb begin
      sel_pin   = pin_ff[tgt_ff];
      sel_file  = file_ff[tgt_ff];
      sel_block = block_ff[tgt_ff];
      sel_lsn   = lsn_ff[tgt_ff];
      sel_valid = valid_ff[tgt_ff];
      sel_dirty = dirty_ff[tgt_ff];
      rem_next  = rem_ff & ~(SCAN_FRAMES'(1) << tgt_ff);

      r_status  = STAT_OK;
      r_frame   = '0;
      r_hit     = 1'b0;
      r_fetch   = 1'b0;
      r_wb      = 1'b0;
      r_wbf     = '0;
      r_wbb     = '0;
      r_wbl     = NO_LSN;
      r_more    = 1'b0;
      pin_we    = 1'b0;
      pin_wdata = sel_pin;
      tag_we    = 1'b0;
      dirty_clr = 1'b0;
      dirty_set = 1'b0;
      txn_we    = 1'b0;
      lsn_we    = 1'b0;
      avail_inc = 1'b0;
      avail_dec = 1'b0;

      case (op_ff)
         OP_PIN: begin
            if (hit_ff) begin
               r_frame = INDEX_BITS'(tgt_ff);
               r_hit   = 1'b1;
               if (sel_pin == PIN_MAX) begin
                  r_status = STAT_PIN_SAT;
               end else begin
                  pin_we    = 1'b1;
                  pin_wdata = sel_pin + PIN_BITS'(1);
                  avail_dec = (sel_pin == '0);
               end
            end else if (!free_ff) begin
               r_status = STAT_NO_FRAME;
            end else begin
               r_frame   = INDEX_BITS'(tgt_ff);
               r_fetch   = 1'b1;
               tag_we    = 1'b1;
               pin_we    = 1'b1;
               pin_wdata = PIN_BITS'(1);
               avail_dec = 1'b1;
               if (sel_valid && sel_dirty) begin
                  r_wb      = 1'b1;
                  r_wbf     = sel_file;
                  r_wbb     = sel_block;
                  r_wbl     = sel_lsn;
                  dirty_clr = 1'b1;
               end
            end
         end
         OP_UNPIN: begin
            if (!fi_ok_ff || (sel_pin == '0)) begin
               r_status = STAT_UNPIN_ERR;
            end else begin
               pin_we    = 1'b1;
               pin_wdata = sel_pin - PIN_BITS'(1);
               avail_inc = (sel_pin == PIN_BITS'(1));
            end
         end
         OP_MODIFY: begin
            if (fi_ok_ff && sel_valid) begin
               dirty_set = 1'b1;
               txn_we    = 1'b1;
               lsn_we    = !rq_lsn_ff[LSN_BITS-1];
            end
         end
         OP_FLUSH: begin
            if (rem_ff != '0) begin
               r_frame   = INDEX_BITS'(tgt_ff);
               r_wb      = 1'b1;
               r_wbf     = sel_file;
               r_wbb     = sel_block;
               r_wbl     = sel_lsn;
               dirty_clr = 1'b1;
               r_more    = (rem_next != '0) && (k_ff != K_LAST);
            end
         end
         default: begin
            r_status = STAT_OK;
         end
      endcase
      r_last = !r_more;
      avail_next = avail_ff + AVAIL_BITS'(avail_inc) - AVAIL_BITS'(avail_dec);
   end

   always_comb begin
      sts.out_free   = !rsp_valid_ff || rsp_ready;
      sts.more       = r_more;
      sts.count_done = FIU_BITS'(scan_ff) == (act_n_ff - FIU_BITS'(1));
   end

   // next state of control registers
   always_comb begin
      valid_in     = valid_ff;
      dirty_in     = dirty_ff;
      avail_in     = avail_ff;
      act_n_in     = act_n_ff;
      scan_in      = scan_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      tgt_in       = tgt_ff;
      if (cmd.count_start) begin
         act_n_in = clamp_active(csr_write_data);
         avail_in = '0;
         scan_in  = '0;
      end
      if (cmd.count_step) begin
         avail_in = avail_ff + AVAIL_BITS'(pin_zero[scan_ff]);
         scan_in  = scan_ff + TGT_BITS'(1);
      end
      if (cmd.lookup) begin
         tgt_in = look_tgt;
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         avail_in     = avail_next;
         if (tag_we) begin
            valid_in[tgt_ff] = 1'b1;
         end
         if (dirty_clr) begin
            dirty_in[tgt_ff] = 1'b0;
         end
         if (dirty_set) begin
            dirty_in[tgt_ff] = 1'b1;
         end
         if (op_ff == OP_FLUSH) begin
            tgt_in = first_set(rem_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         dirty_ff     <= '0;
         avail_ff     <= AVAIL_BITS'(clamp_active(FIU_RESET));
         act_n_ff     <= clamp_active(FIU_RESET);
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         avail_ff     <= avail_in;
         act_n_ff     <= act_n_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SCAN_FRAMES; i++) begin
            pin_ff[i] <= '0;
            lsn_ff[i] <= NO_LSN;
         end
      end else if (cmd.commit) begin
         if (pin_we) begin
            pin_ff[tgt_ff] <= pin_wdata;
         end
         if (lsn_we) begin
            lsn_ff[tgt_ff] <= rq_lsn_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff <= tgt_in;
      if (cmd.lookup) begin
         op_ff       <= req_op;
         rq_file_ff  <= req_file_id;
         rq_block_ff <= req_block_number;
         rq_txn_ff   <= req_txn_id;
         rq_lsn_ff   <= req_log_seq;
         fi_ok_ff    <= req_fi_ok;
         hit_ff      <= hit_vec != '0;
         free_ff     <= free_vec != '0;
         rem_ff      <= flush_vec;
         k_ff        <= '0;
      end
      if (cmd.commit) begin
         if (tag_we) begin
            file_ff[tgt_ff]  <= rq_file_ff;
            block_ff[tgt_ff] <= rq_block_ff;
         end
         if (txn_we) begin
            txn_ff[tgt_ff] <= rq_txn_ff;
         end
         if (op_ff == OP_FLUSH) begin
            rem_ff <= rem_next;
            k_ff   <= k_ff + K_BITS'(1);
         end
         rsp_status_ff <= r_status;
         rsp_frame_ff  <= r_frame;
         rsp_hit_ff    <= r_hit;
         rsp_fetch_ff  <= r_fetch;
         rsp_wb_ff     <= r_wb;
         rsp_wbf_ff    <= r_wbf;
         rsp_wbb_ff    <= r_wbb;
         rsp_wbl_ff    <= r_wbl;
         rsp_avail_ff  <= avail_next;
         rsp_last_ff   <= r_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_frame   = rsp_frame_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_fetch           = rsp_fetch_ff;
   assign rsp_writeback       = rsp_wb_ff;
   assign rsp_wb_file_id      = rsp_wbf_ff;
   assign rsp_wb_block_number = rsp_wbb_ff;
   assign rsp_wb_log_seq      = rsp_wbl_ff;
   assign rsp_available       = rsp_avail_ff;
   assign rsp_last            = rsp_last_ff;

   a_avail_bound: assert property (@(posedge clock) disable iff (reset)
      avail_ff <= act_n_ff)
      else $error("available count above active frame count");

   a_flush_shrink: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && op_ff == OP_FLUSH |=> (rem_ff & ~$past(rem_ff)) == '0)
      else $error("flush set gained a frame");

   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");

endmodule

### rtl/buffer_pool_pin_manager_unit.sv
// Top level of the buffer pool pin manager: controller plus frame table datapath.
//
//   port group | direction | handshake                | payload
//   req_       | in        | req_valid / req_ready    | operation, tag, frame, txn, log seq
//   rsp_       | out       | rsp_valid / rsp_ready    | status, frame, flags, write-back, count
//   csr_       | in        | csr_write_enable         | frames_in_use
//
// Pin, unpin and modify do the tag compare across all frames at accept, then the
// frame update and result register load.
// Flush gives one write-back result per cycle while the result side is not stalled,
// at most 8, and a single result when no frame matches.
// A register write recounts free frames one active frame a cycle; requests are
// held off while the write is asserted and until all active frames are counted.
// Reset is synchronous; it clears pins, dirty and valid marks and log numbers.
// A stalled result holds the update stage; the request side opens once it drains.
module buffer_pool_pin_manager_unit
   import bppm_pkg::*;
#(
   parameter int POOL_FRAMES = POOL_FRAMES_DEF,
   parameter int PIN_BITS    = PIN_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [OP_BITS-1:0]          req_operation,
   input  logic [FILE_BITS-1:0]        req_file_id,
   input  logic [BLOCK_BITS-1:0]       req_block_number,
   input  logic [INDEX_BITS-1:0]       req_frame_index,
   input  logic [TXN_BITS-1:0]         req_txn_id,
   input  logic signed [LSN_BITS-1:0]  req_log_seq,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [STATUS_BITS-1:0]      rsp_status,
   output logic [INDEX_BITS-1:0]       rsp_granted_frame,
   output logic                        rsp_hit,
   output logic                        rsp_fetch,
   output logic                        rsp_writeback,
   output logic [FILE_BITS-1:0]        rsp_wb_file_id,
   output logic [BLOCK_BITS-1:0]       rsp_wb_block_number,
   output logic signed [LSN_BITS-1:0]  rsp_wb_log_seq,
   output logic [AVAIL_BITS-1:0]       rsp_available,
   output logic                        rsp_last,
   input  logic                        csr_write_enable,
   input  logic [FIU_BITS-1:0]         csr_write_data
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   bppm_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .csr_write_enable (csr_write_enable),
      .sts              (sts),
      .cmd              (cmd)
   );

   bppm_datapath #(
      .POOL_FRAMES (POOL_FRAMES),
      .PIN_BITS    (PIN_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .csr_write_data      (csr_write_data),
      .req_operation       (req_operation),
      .req_file_id         (req_file_id),
      .req_block_number    (req_block_number),
      .req_frame_index     (req_frame_index),
      .req_txn_id          (req_txn_id),
      .req_log_seq         (req_log_seq),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_granted_frame   (rsp_granted_frame),
      .rsp_hit             (rsp_hit),
      .rsp_fetch           (rsp_fetch),
      .rsp_writeback       (rsp_writeback),
      .rsp_wb_file_id      (rsp_wb_file_id),
      .rsp_wb_block_number (rsp_wb_block_number),
      .rsp_wb_log_seq      (rsp_wb_log_seq),
      .rsp_available       (rsp_available),
      .rsp_last            (rsp_last)
   );

endmodule

### verif/tb_top.sv
// Self-checking testbench for the buffer pool pin manager frame table.
`timescale 1ns / 1ps

module tb_top;
   import bppm_pkg::*;

   localparam int POOL        = POOL_FRAMES_DEF;
   localparam int PIN_LIMIT   = (1 << PIN_BITS_DEF) - 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SATURATE_PINS = 256;
   localparam int PHASE_REQUESTS = 32;

   typedef struct packed {
      op_type                       op;
      logic [FILE_BITS-1:0]         file;
      logic [BLOCK_BITS-1:0]        blk;
      logic [INDEX_BITS-1:0]        frame;
      logic [TXN_BITS-1:0]          txn;
      logic signed [LSN_BITS-1:0]   lsn;
   } pool_req_type;

   typedef struct packed {
      rsp_status_type               status;
      logic [INDEX_BITS-1:0]        frame;
      logic                         hit;
      logic                         fetch;
      logic                         wb;
      logic [FILE_BITS-1:0]         wb_file;
      logic [BLOCK_BITS-1:0]        wb_block;
      logic signed [LSN_BITS-1:0]   wb_lsn;
      logic [AVAIL_BITS-1:0]        avail;
      logic                         last;
   } pool_rsp_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [OP_BITS-1:0]         req_operation = '0;
   logic [FILE_BITS-1:0]       req_file_id = '0;
   logic [BLOCK_BITS-1:0]      req_block_number = '0;
   logic [INDEX_BITS-1:0]      req_frame_index = '0;
   logic [TXN_BITS-1:0]        req_txn_id = '0;
   logic signed [LSN_BITS-1:0] req_log_seq = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [STATUS_BITS-1:0]     rsp_status;
   logic [INDEX_BITS-1:0]      rsp_granted_frame;
   logic                       rsp_hit;
   logic                       rsp_fetch;
   logic                       rsp_writeback;
   logic [FILE_BITS-1:0]       rsp_wb_file_id;
   logic [BLOCK_BITS-1:0]      rsp_wb_block_number;
   logic signed [LSN_BITS-1:0] rsp_wb_log_seq;
   logic [AVAIL_BITS-1:0]      rsp_available;
   logic                       rsp_last;
   logic                       csr_write_enable = 1'b0;
   logic [FIU_BITS-1:0]        csr_write_data = '0;

   buffer_pool_pin_manager_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_file_id         (req_file_id),
      .req_block_number    (req_block_number),
      .req_frame_index     (req_frame_index),
      .req_txn_id          (req_txn_id),
      .req_log_seq         (req_log_seq),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_granted_frame   (rsp_granted_frame),
      .rsp_hit             (rsp_hit),
      .rsp_fetch           (rsp_fetch),
      .rsp_writeback       (rsp_writeback),
      .rsp_wb_file_id      (rsp_wb_file_id),
      .rsp_wb_block_number (rsp_wb_block_number),
      .rsp_wb_log_seq      (rsp_wb_log_seq),
      .rsp_available       (rsp_available),
      .rsp_last            (rsp_last),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // frame table shadow
   logic                       tag_valid [POOL];
   logic [FILE_BITS-1:0]       tag_file [POOL];
   logic [BLOCK_BITS-1:0]      tag_block [POOL];
   int unsigned                pin_depth [POOL];
   logic                       dirty [POOL];
   logic [TXN_BITS-1:0]        dirty_txn [POOL];
   logic signed [LSN_BITS-1:0] page_lsn [POOL];
   int unsigned                free_frames;
   logic [FIU_BITS-1:0]        pool_size_reg;

   pool_req_type   pending_requests[$];
   pool_rsp_type   owed_responses[$];
   pool_req_type   offered_req;
   pool_rsp_type   seen_rsp;
   pool_rsp_type   want_rsp;

   int          sender_idle_pct = 25;
   int          receiver_idle_pct = 84;
   int          requests_accepted = 0;
   int          responses_checked = 0;
   int          writebacks_seen = 0;
   int          status_seen [4] = '{0, 0, 0, 0};
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          stall_cycles = 0;
   logic        stall_done = 1'b0;

   function automatic int unsigned active_count(logic [FIU_BITS-1:0] value);
      if (value == 0) return 1;
      if (value > POOL) return POOL;
      return 32'(value);
   endfunction

   function automatic void recount_free();
      int unsigned n;
      int i;
      n = active_count(pool_size_reg);
      free_frames = 0;
      for (i = 0; i < n; i++)
         if (pin_depth[i] == 0) free_frames++;
   endfunction

   function automatic pool_rsp_type result_of(rsp_status_type status, int frame, logic hit,
                                              logic fetch, logic wb,
                                              logic [FILE_BITS-1:0] wbf,
                                              logic [BLOCK_BITS-1:0] wbb,
                                              logic signed [LSN_BITS-1:0] wbl, logic last);
      pool_rsp_type o;
      o.status   = status;
      o.frame    = INDEX_BITS'(frame);
      o.hit      = hit;
      o.fetch    = fetch;
      o.wb       = wb;
      o.wb_file  = wbf;
      o.wb_block = wbb;
      o.wb_lsn   = wbl;
      o.avail    = AVAIL_BITS'(free_frames);
      o.last     = last;
      return o;
   endfunction

   task automatic frame_table_apply(input pool_req_type r);
      int unsigned n;
      int found;
      int total;
      int k;
      int i;
      logic wb;
      logic [FILE_BITS-1:0] wbf;
      logic [BLOCK_BITS-1:0] wbb;
      logic signed [LSN_BITS-1:0] wbl;
      n = active_count(pool_size_reg);
      found = -1;
      case (r.op)
         OP_PIN: begin
            for (i = 0; i < n; i++)
               if (found < 0 && tag_valid[i] && tag_file[i] == r.file && tag_block[i] == r.blk)
                  found = i;
            if (found >= 0) begin
               if (pin_depth[found] >= PIN_LIMIT) begin
                  owed_responses.push_back(result_of(STAT_PIN_SAT, found, 1'b1, 1'b0, 1'b0,
                                                     '0, '0, NO_LSN, 1'b1));
               end else begin
                  if (pin_depth[found] == 0 && free_frames > 0) free_frames--;
                  pin_depth[found]++;
                  owed_responses.push_back(result_of(STAT_OK, found, 1'b1, 1'b0, 1'b0,
                                                     '0, '0, NO_LSN, 1'b1));
               end
            end else begin
               for (i = 0; i < n; i++)
                  if (found < 0 && pin_depth[i] == 0) found = i;
               if (found < 0) begin
                  owed_responses.push_back(result_of(STAT_NO_FRAME, 0, 1'b0, 1'b0, 1'b0,
                                                     '0, '0, NO_LSN, 1'b1));
               end else begin
                  wb = 1'b0;
                  wbf = '0;
                  wbb = '0;
                  wbl = NO_LSN;
                  if (tag_valid[found] && dirty[found]) begin
                     wb = 1'b1;
                     wbf = tag_file[found];
                     wbb = tag_block[found];
                     wbl = page_lsn[found];
                     dirty[found] = 1'b0;
                  end
                  tag_valid[found] = 1'b1;
                  tag_file[found] = r.file;
                  tag_block[found] = r.blk;
                  pin_depth[found] = 1;
                  if (free_frames > 0) free_frames--;
                  owed_responses.push_back(result_of(STAT_OK, found, 1'b0, 1'b1, wb,
                                                     wbf, wbb, wbl, 1'b1));
               end
            end
         end
         OP_UNPIN: begin
            if (r.frame >= n || pin_depth[r.frame] == 0) begin
               owed_responses.push_back(result_of(STAT_UNPIN_ERR, 0, 1'b0, 1'b0, 1'b0,
                                                  '0, '0, NO_LSN, 1'b1));
            end else begin
               pin_depth[r.frame]--;
               if (pin_depth[r.frame] == 0) free_frames++;
               owed_responses.push_back(result_of(STAT_OK, 0, 1'b0, 1'b0, 1'b0,
                                                  '0, '0, NO_LSN, 1'b1));
            end
         end
         OP_MODIFY: begin
            if (r.frame < n && tag_valid[r.frame]) begin
               dirty[r.frame] = 1'b1;
               dirty_txn[r.frame] = r.txn;
               if (r.lsn >= 0) page_lsn[r.frame] = r.lsn;
            end
            owed_responses.push_back(result_of(STAT_OK, 0, 1'b0, 1'b0, 1'b0,
                                               '0, '0, NO_LSN, 1'b1));
         end
         default: begin
            total = 0;
            for (i = 0; i < n; i++)
               if (dirty[i] && tag_valid[i] && dirty_txn[i] == r.txn && total < MAX_RESULTS)
                  total++;
            if (total == 0) begin
               owed_responses.push_back(result_of(STAT_OK, 0, 1'b0, 1'b0, 1'b0,
                                                  '0, '0, NO_LSN, 1'b1));
            end else begin
               k = 0;
               for (i = 0; i < n && k < total; i++) begin
                  if (dirty[i] && tag_valid[i] && dirty_txn[i] == r.txn) begin
                     dirty[i] = 1'b0;
                     owed_responses.push_back(result_of(STAT_OK, i, 1'b0, 1'b0, 1'b1,
                                                        tag_file[i], tag_block[i],
                                                        page_lsn[i], k == total - 1));
                     k++;
                  end
               end
            end
         end
      endcase
   endtask

   function automatic pool_req_type make_req(op_type op, logic [FILE_BITS-1:0] file,
                                             logic [BLOCK_BITS-1:0] blk,
                                             logic [INDEX_BITS-1:0] frame,
                                             logic [TXN_BITS-1:0] txn,
                                             logic signed [LSN_BITS-1:0] lsn);
      pool_req_type r;
      r.op    = op;
      r.file  = file;
      r.blk   = blk;
      r.frame = frame;
      r.txn   = txn;
      r.lsn   = lsn;
      return r;
   endfunction

   function automatic pool_req_type random_request(int unsigned n);
      pool_req_type r;
      int unsigned roll;
      roll = $urandom_range(99);
      r.op = (roll < 40) ? OP_PIN : (roll < 70) ? OP_UNPIN : (roll < 88) ? OP_MODIFY : OP_FLUSH;
      if ($urandom_range(99) < 85) begin
         r.file = FILE_BITS'($urandom_range(3));
         r.blk  = BLOCK_BITS'($urandom_range(5));
      end else begin
         r.file = FILE_BITS'($urandom);
         r.blk  = $urandom;
      end
      if ($urandom_range(99) < 85)
         r.frame = INDEX_BITS'($urandom_range(n - 1));
      else
         r.frame = INDEX_BITS'($urandom_range(7));
      if ($urandom_range(99) < 80)
         r.txn = TXN_BITS'($urandom_range(3));
      else
         r.txn = TXN_BITS'($urandom);
      roll = $urandom_range(99);
      if (roll < 30)
         r.lsn = NO_LSN;
      else if (roll < 50)
         r.lsn = $urandom;
      else
         r.lsn = {1'b0, 31'($urandom)};
      return r;
   endfunction

   function automatic string rsp_text(pool_rsp_type r);
      return {$sformatf("st=%0d fr=%0d hit=%0b fetch=%0b wb=%0b ",
                        r.status, r.frame, r.hit, r.fetch, r.wb),
              $sformatf("file=%h blk=%h lsn=%0d avail=%0d last=%0b",
                        r.wb_file, r.wb_block, r.wb_lsn, r.avail, r.last)};
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            frame_table_apply(offered_req);
            requests_accepted <= requests_accepted + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               offered_req = pending_requests.pop_front();
               req_valid        <= 1'b1;
               req_operation    <= offered_req.op;
               req_file_id      <= offered_req.file;
               req_block_number <= offered_req.blk;
               req_frame_index  <= offered_req.frame;
               req_txn_id       <= offered_req.txn;
               req_log_seq      <= offered_req.lsn;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off while requests keep coming
   always @(posedge clock) begin
      if (stall_cycles != 0)
         stall_cycles <= stall_cycles - 1;
      else if (!stall_done && requests_accepted >= 40) begin
         stall_cycles <= 120;
         stall_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= (stall_cycles == 0) && ($urandom_range(99) >= receiver_idle_pct);
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_rsp.status   = rsp_status_type'(rsp_status);
         seen_rsp.frame    = rsp_granted_frame;
         seen_rsp.hit      = rsp_hit;
         seen_rsp.fetch    = rsp_fetch;
         seen_rsp.wb       = rsp_writeback;
         seen_rsp.wb_file  = rsp_wb_file_id;
         seen_rsp.wb_block = rsp_wb_block_number;
         seen_rsp.wb_lsn   = rsp_wb_log_seq;
         seen_rsp.avail    = rsp_available;
         seen_rsp.last     = rsp_last;
         status_seen[rsp_status]++;
         if (rsp_writeback) writebacks_seen++;
         if (owed_responses.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected response: %s", rsp_text(seen_rsp));
            mismatch_count++;
         end else begin
            want_rsp = owed_responses.pop_front();
            responses_checked++;
            if (seen_rsp !== want_rsp) begin
               if (mismatch_count < 10) begin
                  $display("mismatch at response %0d", responses_checked);
                  $display("  expected %s", rsp_text(want_rsp));
                  $display("  actual   %s", rsp_text(seen_rsp));
               end
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, owed_responses.size());
         $display("tb_top: errors");
         $finish;
      end
   end

   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_valid || owed_responses.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_pool_size(input logic [FIU_BITS-1:0] value);
      wait_idle();
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      pool_size_reg = value;
      recount_free();
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_random(input int count, input int s_idle, input int r_idle);
      int j;
      @(negedge clock);
      sender_idle_pct = s_idle;
      receiver_idle_pct = r_idle;
      for (j = 0; j < count; j++)
         pending_requests.push_back(random_request(active_count(pool_size_reg)));
   endtask

   initial begin
      int i;
      for (i = 0; i < POOL; i++) begin
         tag_valid[i] = 1'b0;
         tag_file[i]  = '0;
         tag_block[i] = '0;
         pin_depth[i] = 0;
         dirty[i]     = 1'b0;
         dirty_txn[i] = '0;
         page_lsn[i]  = NO_LSN;
      end
      pool_size_reg = FIU_RESET;
      recount_free();

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty pool corner cases, fill every frame, then mass flush
      pending_requests.push_back(make_req(OP_UNPIN, '0, '0, 3'd0, '0, NO_LSN));
      pending_requests.push_back(make_req(OP_MODIFY, '0, '0, 3'd3, 16'd1, 32'sd5));
      pending_requests.push_back(make_req(OP_FLUSH, '1, '1, 3'd7, 16'd0, NO_LSN));
      pending_requests.push_back(make_req(OP_PIN, 16'h0000, 32'h0000_0000, 3'd7, '1, '0));
      pending_requests.push_back(make_req(OP_PIN, 16'hFFFF, 32'hFFFF_FFFF, 3'd0, '0, '1));
      pending_requests.push_back(make_req(OP_PIN, 16'h5555, 32'hAAAA_AAAA, 3'd5, '0, '0));
      pending_requests.push_back(make_req(OP_PIN, 16'hAAAA, 32'h5555_5555, 3'd2, '0, '0));
      for (i = 4; i < POOL; i++)
         pending_requests.push_back(make_req(OP_PIN, FILE_BITS'(i), $urandom,
                                             '0, '0, '0));
      pending_requests.push_back(make_req(OP_PIN, 16'h1234, 32'd1, '0, '0, '0));
      pending_requests.push_back(make_req(OP_PIN, 16'h0000, 32'h0000_0000, '0, '0, '0));
      pending_requests.push_back(make_req(OP_MODIFY, '0, '0, 3'd0, 16'hFFFF, 32'sd0));
      pending_requests.push_back(make_req(OP_MODIFY, '0, '0, 3'd1, 16'hFFFF, 32'sh7FFF_FFFF));
      pending_requests.push_back(make_req(OP_MODIFY, '0, '0, 3'd2, 16'hFFFF, NO_LSN));
      pending_requests.push_back(make_req(OP_MODIFY, '0, '0, 3'd3, 16'hFFFF, 32'sh8000_0000));
      for (i = 4; i < POOL; i++)
         pending_requests.push_back(make_req(OP_MODIFY, '0, '0, INDEX_BITS'(i), 16'hFFFF,
                                             {1'b0, 31'($urandom)}));
      pending_requests.push_back(make_req(OP_FLUSH, '0, '0, '0, 16'hFFFF, '0));
      pending_requests.push_back(make_req(OP_UNPIN, '0, '0, 3'd0, '0, '0));
      pending_requests.push_back(make_req(OP_UNPIN, '0, '0, 3'd0, '0, '0));
      pending_requests.push_back(make_req(OP_MODIFY, '0, '0, 3'd0, 16'd9, 32'sd123));
      pending_requests.push_back(make_req(OP_PIN, 16'h4321, 32'd9, '0, '0, '0));

      // drive one frame past its pin count limit
      for (i = 0; i < SATURATE_PINS; i++)
         pending_requests.push_back(make_req(OP_PIN, 16'hFFFF, 32'hFFFF_FFFF,
                                             INDEX_BITS'(i), TXN_BITS'(i), '0));

      write_pool_size(4'd3);
      run_random(PHASE_REQUESTS, 25, 84);
      write_pool_size(4'd0);
      run_random(PHASE_REQUESTS, 25, 84);
      write_pool_size(4'd15);
      run_random(PHASE_REQUESTS, 84, 25);
      write_pool_size(4'd8);
      run_random(PHASE_REQUESTS, 84, 25);
      write_pool_size(4'd5);
      run_random(PHASE_REQUESTS, 0, 0);
      write_pool_size(4'd1);
      run_random(PHASE_REQUESTS, 0, 0);

      wait_idle();
      repeat (20) @(negedge clock);

      $display("covered %0d requests over pool sizes 8,3,0,15,8,5,1, %0d responses checked",
               requests_accepted, responses_checked);
      $display("  %0d write-backs; status ok/no-frame/unpin-error/saturated = %0d/%0d/%0d/%0d",
               writebacks_seen, status_seen[0], status_seen[1], status_seen[2],
               status_seen[3]);
      if (mismatch_count == 0 && owed_responses.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/bppm_pkg.sv
rtl/bppm_ctrl.sv
rtl/bppm_datapath.sv
rtl/buffer_pool_pin_manager_unit.sv
verif/tb_top.sv
